/* hw/rtl/ima_pkg.sv */
// Shared types, constants and table functions of the IMA ADPCM clip decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package ima_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [6:0] MAX_STEP_INDEX = 7'd88;
	localparam logic signed [17:0] PCM_MAX = 18'sd32767;
	localparam logic signed [17:0] PCM_MIN = -18'sd32768;

	// input opcodes
	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_PREDICTOR = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_STEP_INDEX = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_COUNT = 2'd2;

	typedef struct packed {
		logic signed [15:0] predictor;
		logic [6:0] step_index;
	} ima_state_t;

	function automatic logic [6:0] clamp_index(input logic [6:0] idx);
		return (idx > MAX_STEP_INDEX) ? MAX_STEP_INDEX : idx;
	endfunction

	// signed index change per code (low three bits matter)
	function automatic logic signed [4:0] index_adjust(input logic [3:0] code);
		logic signed [4:0] adj;
		case (code[2:0])
			3'd4: adj = 5'sd2;
			3'd5: adj = 5'sd4;
			3'd6: adj = 5'sd6;
			3'd7: adj = 5'sd8;
			default: adj = -5'sd1;
		endcase
		return adj;
	endfunction

	function automatic logic [14:0] step_size(input logic [6:0] idx);
		logic [14:0] s;
		case (idx)
			7'd0: s = 15'd7;        7'd1: s = 15'd8;        7'd2: s = 15'd9;
			7'd3: s = 15'd10;       7'd4: s = 15'd11;       7'd5: s = 15'd12;
			7'd6: s = 15'd13;       7'd7: s = 15'd14;       7'd8: s = 15'd16;
			7'd9: s = 15'd17;       7'd10: s = 15'd19;      7'd11: s = 15'd21;
			7'd12: s = 15'd23;      7'd13: s = 15'd25;      7'd14: s = 15'd28;
			7'd15: s = 15'd31;      7'd16: s = 15'd34;      7'd17: s = 15'd37;
			7'd18: s = 15'd41;      7'd19: s = 15'd45;      7'd20: s = 15'd50;
			7'd21: s = 15'd55;      7'd22: s = 15'd60;      7'd23: s = 15'd66;
			7'd24: s = 15'd73;      7'd25: s = 15'd80;      7'd26: s = 15'd88;
			7'd27: s = 15'd97;      7'd28: s = 15'd107;     7'd29: s = 15'd118;
			7'd30: s = 15'd130;     7'd31: s = 15'd143;     7'd32: s = 15'd157;
			7'd33: s = 15'd173;     7'd34: s = 15'd190;     7'd35: s = 15'd209;
			7'd36: s = 15'd230;     7'd37: s = 15'd253;     7'd38: s = 15'd279;
			7'd39: s = 15'd307;     7'd40: s = 15'd337;     7'd41: s = 15'd371;
			7'd42: s = 15'd408;     7'd43: s = 15'd449;     7'd44: s = 15'd494;
			7'd45: s = 15'd544;     7'd46: s = 15'd598;     7'd47: s = 15'd658;
			7'd48: s = 15'd724;     7'd49: s = 15'd796;     7'd50: s = 15'd876;
			7'd51: s = 15'd963;     7'd52: s = 15'd1060;    7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;    7'd55: s = 15'd1411;    7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;    7'd58: s = 15'd1878;    7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;    7'd61: s = 15'd2499;    7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;    7'd64: s = 15'd3327;    7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;    7'd67: s = 15'd4428;    7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;    7'd70: s = 15'd5894;    7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;    7'd73: s = 15'd7845;    7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;    7'd76: s = 15'd10442;   7'd77: s = 15'd11487;
			7'd78: s = 15'd12635;   7'd79: s = 15'd13899;   7'd80: s = 15'd15289;
			7'd81: s = 15'd16818;   7'd82: s = 15'd18500;   7'd83: s = 15'd20350;
			7'd84: s = 15'd22385;   7'd85: s = 15'd24623;   7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ima_cfg_regs.sv */
// Configuration register file: initial predictor, initial step index, sample count.
// Depends on ima_pkg.
`default_nettype none

module ima_cfg_regs #(
	parameter int COUNT_WIDTH = ima_pkg::COUNT_WIDTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [ima_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [ima_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output      ima_pkg::ima_state_t                  init_state,
	output      logic [COUNT_WIDTH-1:0]               sample_count
);

	logic signed [15:0] init_pred_q;
	logic [6:0] init_idx_q;
	logic [COUNT_WIDTH-1:0] count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_pred_q <= '0;
			init_idx_q <= '0;
			count_q <= {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
		end else if (cfg_valid) begin
			case (cfg_index)
				ima_pkg::REG_INIT_PREDICTOR: init_pred_q <= cfg_data[15:0];
				ima_pkg::REG_INIT_STEP_INDEX: init_idx_q <= cfg_data[6:0];
				ima_pkg::REG_SAMPLE_COUNT: count_q <= cfg_data[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign init_state.predictor = init_pred_q;
	assign init_state.step_index = init_idx_q;
	assign sample_count = count_q;

endmodule

`default_nettype wire

/* hw/rtl/ima_nibble_dec.sv */
// One 4-bit ADPCM code step: predictor update with saturation, step index update.
// Depends on ima_pkg (step table, index adjust, types).
`default_nettype none

module ima_nibble_dec (
	input  wire ima_pkg::ima_state_t cur,
	input  wire logic [3:0]          code,
	output      ima_pkg::ima_state_t nxt
);

	logic [6:0] idx;
	logic [14:0] step;
	logic [16:0] diff;
	logic signed [17:0] sum;
	logic signed [7:0] ni;

	always_comb begin
		idx = ima_pkg::clamp_index(cur.step_index);
		step = ima_pkg::step_size(idx);
		diff = {5'd0, step[14:3]};
		if (code[0]) diff = diff + {4'd0, step[14:2]};
		if (code[1]) diff = diff + {3'd0, step[14:1]};
		if (code[2]) diff = diff + {2'd0, step};
		if (code[3]) sum = {{2{cur.predictor[15]}}, cur.predictor} - $signed({1'b0, diff});
		else sum = {{2{cur.predictor[15]}}, cur.predictor} + $signed({1'b0, diff});

		if (sum > ima_pkg::PCM_MAX) nxt.predictor = ima_pkg::PCM_MAX[15:0];
		else if (sum < ima_pkg::PCM_MIN) nxt.predictor = ima_pkg::PCM_MIN[15:0];
		else nxt.predictor = sum[15:0];

		ni = $signed({1'b0, idx}) + 8'(ima_pkg::index_adjust(code));
		if (ni < 0) nxt.step_index = 7'd0;
		else if (ni > $signed({1'b0, ima_pkg::MAX_STEP_INDEX}))
			nxt.step_index = ima_pkg::MAX_STEP_INDEX;
		else nxt.step_index = ni[6:0];
	end

endmodule

`default_nettype wire

/* hw/rtl/ima_adpcm_clip_decoder_core.sv */
// Top level of the IMA ADPCM clip decoder: input register, nibble sequencing,
// decoder state and output register. Depends on ima_pkg, ima_cfg_regs, ima_nibble_dec.
`default_nettype none

// Decodes a 4-bit IMA ADPCM clip into signed 16-bit PCM. A restart beat
// (opcode 0) loads predictor and step index from the configuration
// registers and returns the initial predictor as sample zero; a data beat
// (opcode 1) carries two codes, low nibble first, and returns up to two
// samples. Output stops once sample_count samples are out; the final one
// has end_of_clip set, and last marks the final result of each input beat.
// Data beats before a restart, or after the clip's end, return nothing.
// Nibbles of a data byte go one after the other through the single nibble
// decoder and the single output register; a restart, or a byte that yields
// nothing or whose clip ends after its low nibble, needs no high-nibble step.
// A new input beat is taken in the cycle the previous one finishes, so bytes
// stream with the output port taking one sample per cycle while out_stall is low.
// A beat passes the input register, then the output register. Configuration
// writes are always accepted (cfg_ready is high) and should be made idle.

module ima_adpcm_clip_decoder_core #(
	parameter int COUNT_WIDTH = ima_pkg::COUNT_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [ima_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [ima_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	// input beats
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic                                opcode,
	input  wire logic [7:0]                          packed_byte,
	// result beats
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic signed [15:0]                  pcm_sample,
	output      logic                                end_of_clip,
	output      logic                                last
);

	ima_pkg::ima_state_t init_state;
	logic [COUNT_WIDTH-1:0] sample_count;

	ima_cfg_regs #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.init_state  (init_state),
		.sample_count(sample_count)
	);

	// input register; nib_s1 selects the nibble being worked on
	logic valid_s1;
	logic opcode_s1;
	logic [7:0] byte_s1;
	logic nib_s1;

	// decoder state
	ima_pkg::ima_state_t state_q;
	logic [COUNT_WIDTH-1:0] pos_q;

	// output register
	logic out_valid_q;
	logic signed [15:0] pcm_q;
	logic eoc_q;
	logic last_q;

	ima_pkg::ima_state_t dec_state;
	logic [3:0] code;
	logic [COUNT_WIDTH-1:0] pos_inc;
	logic is_restart;
	logic emit;
	logic eoc;
	logic done;
	logic slot_free;
	logic go;

	assign code = nib_s1 ? byte_s1[7:4] : byte_s1[3:0];

	ima_nibble_dec u_dec (
		.cur (state_q),
		.code(code),
		.nxt (dec_state)
	);

	always_comb begin
		is_restart = (opcode_s1 == ima_pkg::OP_RESTART);
		pos_inc = pos_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
		if (is_restart) begin
			emit = (sample_count != '0);
			eoc = (sample_count == {{(COUNT_WIDTH-1){1'b0}}, 1'b1});
			done = 1'b1;
		end else begin
			// nothing before a restart or past the clip's end
			emit = (pos_q != '0) && (pos_q < sample_count);
			eoc = (pos_inc == sample_count);
			// a byte ends early when its low nibble closes the clip
			done = !emit || nib_s1 || eoc;
		end
		slot_free = !out_valid_q || !out_stall;
		go = valid_s1 && (!emit || slot_free);
		in_stall = valid_s1 && !(go && done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			nib_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			nib_s1 <= 1'b0;
		end else if (go) begin
			nib_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			opcode_s1 <= opcode;
			byte_s1 <= packed_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			pos_q <= '0;
		end else if (go) begin
			if (is_restart) begin
				state_q.predictor <= init_state.predictor;
				state_q.step_index <= ima_pkg::clamp_index(init_state.step_index);
				pos_q <= emit ? {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : '0;
			end else if (emit) begin
				state_q <= dec_state;
				pos_q <= pos_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && go && emit) begin
			pcm_q <= is_restart ? init_state.predictor : dec_state.predictor;
			eoc_q <= eoc;
			last_q <= is_restart || nib_s1 || eoc;
		end
	end

	assign out_valid = out_valid_q;
	assign pcm_sample = pcm_q;
	assign end_of_clip = eoc_q;
	assign last = last_q;

endmodule

`default_nettype wire
